// File: rtl/pla_pkg.sv
// Shared constants, codes and types of the port lease allocator.
package pla_pkg;

    // Largest pool the default build supports.
    localparam int MAX_PORTS_DEF = 16;

    // Field widths of the channels and the configuration port.
    localparam int ACT_W      = 2;
    localparam int PORT_W     = 16;
    localparam int KEY_W      = 60;
    localparam int KIND_W     = 2;
    localparam int UTIL_W     = 7;
    localparam int POOL_CFG_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register values after reset.
    localparam logic [PORT_W-1:0] PORT_BASE_RST = 16'd8380;
    localparam int                POOL_SIZE_RST = 10;
    localparam logic [15:0]       TIMEOUT_RST   = 16'd60;

    // Scale of the utilization answer.
    localparam int PERCENT = 100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    // Request actions.
    localparam logic [ACT_W-1:0] ACT_LEASE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REPORT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECLAIM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ANSWER  = 2'd2;

    // Port status codes.
    localparam logic [1:0] ST_UNUSED   = 2'd0;
    localparam logic [1:0] ST_ACTIVE   = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;

    // Strobes from the sequencer to the pool storage.
    typedef struct packed {
        logic clear;
        logic st_re;
        logic st_we;
        logic fl_re;
        logic fl_we;
        logic key_re;
        logic key_we;
    } pla_ctl_t;

endpackage

// File: rtl/pla_req_if.sv
// Request channel: valid/ready handshake carrying one request word.
interface pla_req_if;
    logic                         valid;
    logic                         ready;
    logic [pla_pkg::ACT_W-1:0]    action;
    logic [pla_pkg::PORT_W-1:0]   port_number;
    logic [pla_pkg::KEY_W-1:0]    session_key;

    modport source (output valid, output action, output port_number, output session_key,
                    input ready);
    modport sink   (input valid, input action, input port_number, input session_key,
                    output ready);
endinterface

// File: rtl/pla_rsp_if.sv
// Result channel: valid/ready handshake carrying one result word.
interface pla_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pla_pkg::KIND_W-1:0]   result_kind;
    logic [pla_pkg::PORT_W-1:0]   port_number_res;
    logic [pla_pkg::KEY_W-1:0]    session_key_res;
    logic                         fresh_lease;
    logic [pla_pkg::UTIL_W-1:0]   utilisation_percent;
    logic                         last;

    modport source (output valid, output result_kind, output port_number_res,
                    output session_key_res, output fresh_lease,
                    output utilisation_percent, output last, input ready);
    modport sink   (input valid, input result_kind, input port_number_res,
                    input session_key_res, input fresh_lease,
                    input utilisation_percent, input last, output ready);
endinterface

// File: rtl/port_lease_allocator_aging_top.sv
// Port lease allocator with idle aging: sequencer, configuration registers and result register.
//
// One request word is handled at a time; ready is high only while the sequencer is idle, and a
// finished result waits in an output register so the next request can be taken. Status and key
// memories have one port each and the free list a read and a write port, all with registered
// reads. A lease pops the free list, then grants; a report reads, then writes the status
// (none outside the pool); a tick that does not expire only counts; an expiring tick reads,
// then evaluates each pool entry and ends with the last reclaim word. A query starts the
// divider and waits until it is done. A sweep yields at most one result word per pool entry.
// While the output side stalls with a word waiting, the step that loads the next word holds,
// adding the stall to the time of the request. A pool size write reinitializes the pool in
// the same cycle through per-entry valid bits; stored session keys are kept.
module port_lease_allocator_aging_top #(
    parameter int MAX_PORTS = pla_pkg::MAX_PORTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    pla_req_if.sink                         req,
    pla_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [pla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pla_pkg::CFG_DATA_W-1:0]  cfg_data
);
    localparam int IDX_W    = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
    localparam int CNT_W    = $clog2(MAX_PORTS + 1);
    localparam int DV_W     = $clog2(MAX_PORTS * pla_pkg::PERCENT + 1);
    localparam int POOL_RST = (pla_pkg::POOL_SIZE_RST > MAX_PORTS) ?
                              MAX_PORTS : pla_pkg::POOL_SIZE_RST;

    // Sequencer states.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LS_GRANT = 4'd1;
    localparam logic [3:0] S_RR_GRANT = 4'd2;
    localparam logic [3:0] S_RP_WR    = 4'd3;
    localparam logic [3:0] S_SW_RD    = 4'd4;
    localparam logic [3:0] S_SW_EV    = 4'd5;
    localparam logic [3:0] S_SW_END   = 4'd6;
    localparam logic [3:0] S_Q_WAIT   = 4'd7;

    logic [3:0]                    state_reg, state_next;
    logic [pla_pkg::PORT_W-1:0]    base_reg, base_next;
    logic [CNT_W-1:0]              pool_reg, pool_next;
    logic [15:0]                   tmo_reg, tmo_next;
    logic [IDX_W-1:0]              head_reg, head_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [IDX_W-1:0]              rr_reg, rr_next;
    logic [15:0]                   tick_reg, tick_next;
    logic [IDX_W-1:0]              off_reg, off_next;
    logic [IDX_W-1:0]              sw_reg, sw_next;
    logic                          pend_v_reg, pend_v_next;
    logic [IDX_W-1:0]              pend_reg, pend_next;
    logic [pla_pkg::KEY_W-1:0]     key_in_reg, key_in_next;

    logic                          out_v_reg;
    logic [pla_pkg::KIND_W-1:0]    out_kind_reg;
    logic [pla_pkg::PORT_W-1:0]    out_port_reg;
    logic [pla_pkg::KEY_W-1:0]     out_key_reg;
    logic                          out_fresh_reg;
    logic [pla_pkg::UTIL_W-1:0]    out_util_reg;
    logic                          out_last_reg;

    logic                          out_load;
    logic                          out_free;
    logic [pla_pkg::KIND_W-1:0]    o_kind;
    logic [pla_pkg::PORT_W-1:0]    o_port;
    logic [pla_pkg::KEY_W-1:0]     o_key;
    logic                          o_fresh;
    logic [pla_pkg::UTIL_W-1:0]    o_util;
    logic                          o_last;

    pla_pkg::pla_ctl_t             ctl;
    logic [IDX_W-1:0]              st_addr;
    logic [1:0]                    st_wdata;
    logic [1:0]                    st_rdata;
    logic [IDX_W-1:0]              fl_raddr;
    logic [IDX_W-1:0]              fl_wdata;
    logic [IDX_W-1:0]              fl_rdata;
    logic [IDX_W-1:0]              key_addr;
    logic [pla_pkg::KEY_W-1:0]     key_wdata;
    logic [pla_pkg::KEY_W-1:0]     key_rdata;

    logic                          div_start;
    logic                          div_busy;
    logic [DV_W-1:0]               div_dividend;
    logic [pla_pkg::UTIL_W-1:0]    div_quot;

    logic                          req_acc;
    logic [pla_pkg::PORT_W-1:0]    rp_off;
    logic [15:0]                   tick_inc;
    logic [CNT_W-1:0]              rr_inc;
    logic [IDX_W-1:0]              rr_adv;
    logic [IDX_W-1:0]              head_inc;
    logic [CNT_W:0]                tail_sum;
    logic [IDX_W-1:0]              tail;
    logic [CNT_W-1:0]              used;
    logic                          sw_step;
    logic [pla_pkg::POOL_CFG_W-1:0] cfg_pool_raw;
    logic [CNT_W-1:0]              cfg_pool;

    assign req_acc   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_v_reg || rsp.ready;

    // Address, counter and configuration arithmetic used by the sequencer.
    always_comb
    begin
        rp_off   = req.port_number - base_reg;
        tick_inc = tick_reg + 16'd1;
        rr_inc   = CNT_W'(rr_reg) + CNT_W'(1);
        rr_adv   = (rr_inc >= pool_reg) ? '0 : rr_inc[IDX_W-1:0];
        head_inc = (head_reg == IDX_W'(MAX_PORTS - 1)) ? '0 : head_reg + IDX_W'(1);
        tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(cnt_reg);
        if (tail_sum >= (CNT_W + 1)'(MAX_PORTS))
        begin
            tail = IDX_W'(tail_sum - (CNT_W + 1)'(MAX_PORTS));
        end
        else
        begin
            tail = IDX_W'(tail_sum);
        end
        used         = pool_reg - cnt_reg;
        div_dividend = DV_W'(used) * DV_W'(pla_pkg::PERCENT);
        cfg_pool_raw = cfg_data[pla_pkg::POOL_CFG_W-1:0];
        if (cfg_pool_raw == '0)
        begin
            cfg_pool = CNT_W'(1);
        end
        else if (int'(cfg_pool_raw) > MAX_PORTS)
        begin
            cfg_pool = CNT_W'(MAX_PORTS);
        end
        else
        begin
            cfg_pool = CNT_W'(cfg_pool_raw);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        pool_next   = pool_reg;
        tmo_next    = tmo_reg;
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        rr_next     = rr_reg;
        tick_next   = tick_reg;
        off_next    = off_reg;
        sw_next     = sw_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        key_in_next = key_in_reg;
        ctl         = '0;
        st_addr     = sw_reg;
        st_wdata    = pla_pkg::ST_UNUSED;
        fl_raddr    = head_reg;
        fl_wdata    = sw_reg;
        key_addr    = fl_rdata;
        key_wdata   = key_in_reg;
        div_start   = 1'b0;
        out_load    = 1'b0;
        o_kind      = pla_pkg::KIND_GRANT;
        o_port      = '0;
        o_key       = '0;
        o_fresh     = 1'b0;
        o_util      = '0;
        o_last      = 1'b0;
        sw_step     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    unique case (req.action)
                        pla_pkg::ACT_LEASE:
                        begin
                            if (cnt_reg != '0)
                            begin
                                // Pop the oldest free port.
                                ctl.fl_re   = 1'b1;
                                head_next   = head_inc;
                                cnt_next    = cnt_reg - CNT_W'(1);
                                key_in_next = req.session_key;
                                state_next  = S_LS_GRANT;
                            end
                            else
                            begin
                                // Pool exhausted: share the next port round robin.
                                rr_next    = rr_adv;
                                ctl.key_re = 1'b1;
                                key_addr   = rr_adv;
                                state_next = S_RR_GRANT;
                            end
                        end
                        pla_pkg::ACT_REPORT:
                        begin
                            if (rp_off < pla_pkg::PORT_W'(pool_reg))
                            begin
                                ctl.st_re  = 1'b1;
                                st_addr    = rp_off[IDX_W-1:0];
                                off_next   = rp_off[IDX_W-1:0];
                                state_next = S_RP_WR;
                            end
                        end
                        pla_pkg::ACT_TICK:
                        begin
                            if (tick_inc >= tmo_reg)
                            begin
                                tick_next   = '0;
                                sw_next     = '0;
                                pend_v_next = 1'b0;
                                state_next  = S_SW_RD;
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        pla_pkg::ACT_QUERY:
                        begin
                            div_start  = 1'b1;
                            state_next = S_Q_WAIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LS_GRANT:
            begin
                st_addr = fl_rdata;
                if (out_free)
                begin
                    ctl.key_we = 1'b1;
                    ctl.st_we  = 1'b1;
                    st_wdata   = pla_pkg::ST_ACTIVE;
                    out_load   = 1'b1;
                    o_kind     = pla_pkg::KIND_GRANT;
                    o_port     = base_reg + pla_pkg::PORT_W'(fl_rdata);
                    o_key      = key_in_reg;
                    o_fresh    = 1'b1;
                    o_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RR_GRANT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    o_kind     = pla_pkg::KIND_GRANT;
                    o_port     = base_reg + pla_pkg::PORT_W'(rr_reg);
                    o_key      = key_rdata;
                    o_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RP_WR:
            begin
                // A leased port becomes active again; an unused one is left alone.
                st_addr = off_reg;
                if (st_rdata != pla_pkg::ST_UNUSED)
                begin
                    ctl.st_we = 1'b1;
                    st_wdata  = pla_pkg::ST_ACTIVE;
                end
                state_next = S_IDLE;
            end
            S_SW_RD:
            begin
                ctl.st_re  = 1'b1;
                state_next = S_SW_EV;
            end
            S_SW_EV:
            begin
                if (st_rdata == pla_pkg::ST_INACTIVE)
                begin
                    // Free the port; the previous reclaim word goes out now that it is not last.
                    if (!pend_v_reg || out_free)
                    begin
                        ctl.st_we = 1'b1;
                        st_wdata  = pla_pkg::ST_UNUSED;
                        if (cnt_reg < CNT_W'(MAX_PORTS))
                        begin
                            ctl.fl_we = 1'b1;
                            cnt_next  = cnt_reg + CNT_W'(1);
                        end
                        if (pend_v_reg)
                        begin
                            out_load = 1'b1;
                            o_kind   = pla_pkg::KIND_RECLAIM;
                            o_port   = base_reg + pla_pkg::PORT_W'(pend_reg);
                        end
                        pend_next   = sw_reg;
                        pend_v_next = 1'b1;
                        sw_step     = 1'b1;
                    end
                end
                else
                begin
                    if (st_rdata == pla_pkg::ST_ACTIVE)
                    begin
                        ctl.st_we = 1'b1;
                        st_wdata  = pla_pkg::ST_INACTIVE;
                    end
                    sw_step = 1'b1;
                end
                if (sw_step)
                begin
                    if (CNT_W'(sw_reg) + CNT_W'(1) == pool_reg)
                    begin
                        state_next = S_SW_END;
                    end
                    else
                    begin
                        sw_next    = sw_reg + IDX_W'(1);
                        state_next = S_SW_RD;
                    end
                end
            end
            S_SW_END:
            begin
                if (!pend_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load    = 1'b1;
                    o_kind      = pla_pkg::KIND_RECLAIM;
                    o_port      = base_reg + pla_pkg::PORT_W'(pend_reg);
                    o_last      = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            S_Q_WAIT:
            begin
                if (!div_busy && out_free)
                begin
                    out_load   = 1'b1;
                    o_kind     = pla_pkg::KIND_ANSWER;
                    o_util     = div_quot;
                    o_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Configuration writes; a pool size write reinitializes the pool.
        if (cfg_we)
        begin
            unique case (cfg_index)
                pla_pkg::CFG_PORT_BASE:
                begin
                    base_next = cfg_data;
                end
                pla_pkg::CFG_POOL_SIZE:
                begin
                    pool_next = cfg_pool;
                    ctl.clear = 1'b1;
                    head_next = '0;
                    cnt_next  = cfg_pool;
                    rr_next   = '0;
                    tick_next = '0;
                end
                pla_pkg::CFG_TIMEOUT:
                begin
                    tmo_next = cfg_data;
                end
                default:
                begin
                    base_next = base_reg;
                end
            endcase
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            base_reg   <= pla_pkg::PORT_BASE_RST;
            pool_reg   <= CNT_W'(POOL_RST);
            tmo_reg    <= pla_pkg::TIMEOUT_RST;
            head_reg   <= '0;
            cnt_reg    <= CNT_W'(POOL_RST);
            rr_reg     <= '0;
            tick_reg   <= '0;
            sw_reg     <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            pool_reg   <= pool_next;
            tmo_reg    <= tmo_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            rr_reg     <= rr_next;
            tick_reg   <= tick_next;
            sw_reg     <= sw_next;
            pend_v_reg <= pend_v_next;
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        pend_reg   <= pend_next;
        key_in_reg <= key_in_next;
        if (out_load)
        begin
            out_kind_reg  <= o_kind;
            out_port_reg  <= o_port;
            out_key_reg   <= o_key;
            out_fresh_reg <= o_fresh;
            out_util_reg  <= o_util;
            out_last_reg  <= o_last;
        end
    end

    assign rsp.valid               = out_v_reg;
    assign rsp.result_kind         = out_kind_reg;
    assign rsp.port_number_res     = out_port_reg;
    assign rsp.session_key_res     = out_key_reg;
    assign rsp.fresh_lease         = out_fresh_reg;
    assign rsp.utilisation_percent = out_util_reg;
    assign rsp.last                = out_last_reg;

    // Pool storage.
    pla_pool #(
        .MAX_PORTS (MAX_PORTS)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .st_addr   (st_addr),
        .st_wdata  (st_wdata),
        .st_rdata  (st_rdata),
        .fl_raddr  (fl_raddr),
        .fl_waddr  (tail),
        .fl_wdata  (fl_wdata),
        .fl_rdata  (fl_rdata),
        .key_addr  (key_addr),
        .key_wdata (key_wdata),
        .key_rdata (key_rdata)
    );

    // Divider for the utilization answer.
    pla_div #(
        .MAX_PORTS (MAX_PORTS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (pool_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // The free count never exceeds the pool size.
    a_cnt_le_pool: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pool_reg)
        else $error("free count above pool size");

    // The round-robin pointer stays inside the pool.
    a_rr_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(rr_reg) < pool_reg)
        else $error("round-robin pointer outside pool");

    // The divider is only started when it is free.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // A lease from a non-empty pool takes exactly one free port.
    a_lease_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && req.action == pla_pkg::ACT_LEASE && cnt_reg != '0 && !cfg_we)
        |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("lease did not pop the free list");

    // A new result word never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result word overwritten");

endmodule

// File: rtl/pla_div.sv
// Iterative restoring divider for the utilization answer, one quotient bit per cycle.
module pla_div #(
    parameter int  MAX_PORTS = pla_pkg::MAX_PORTS_DEF,
    localparam int CNT_W     = $clog2(MAX_PORTS + 1),
    localparam int DV_W      = $clog2(MAX_PORTS * pla_pkg::PERCENT + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DV_W-1:0]             dividend,
    input  logic [CNT_W-1:0]            divisor,
    output logic                        busy,
    output logic [pla_pkg::UTIL_W-1:0]  quotient
);
    localparam int STEP_W = $clog2(DV_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DV_W-1]};
        diff      = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DV_W);
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[DV_W-2:0], ge};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[pla_pkg::UTIL_W-1:0];

endmodule

// File: rtl/pla_pool.sv
// Pool storage: one-port status and session key memories and a two-port free-list FIFO.
module pla_pool #(
    parameter int  MAX_PORTS = pla_pkg::MAX_PORTS_DEF,
    localparam int IDX_W     = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pla_pkg::pla_ctl_t           ctl,
    input  logic [IDX_W-1:0]            st_addr,
    input  logic [1:0]                  st_wdata,
    output logic [1:0]                  st_rdata,
    input  logic [IDX_W-1:0]            fl_raddr,
    input  logic [IDX_W-1:0]            fl_waddr,
    input  logic [IDX_W-1:0]            fl_wdata,
    output logic [IDX_W-1:0]            fl_rdata,
    input  logic [IDX_W-1:0]            key_addr,
    input  logic [pla_pkg::KEY_W-1:0]   key_wdata,
    output logic [pla_pkg::KEY_W-1:0]   key_rdata
);
    logic [1:0]                st_mem [MAX_PORTS];
    logic [IDX_W-1:0]          fl_mem [MAX_PORTS];
    logic [pla_pkg::KEY_W-1:0] key_mem [MAX_PORTS];

    logic [MAX_PORTS-1:0]      st_vld_reg;
    logic [MAX_PORTS-1:0]      fl_vld_reg;
    logic                      st_vq_reg;
    logic                      fl_vq_reg;
    logic [1:0]                st_q_reg;
    logic [IDX_W-1:0]          fl_q_reg;
    logic [IDX_W-1:0]          fl_ra_reg;
    logic [pla_pkg::KEY_W-1:0] key_q_reg;

    // Status memory, registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.st_we)
        begin
            st_mem[st_addr] <= st_wdata;
        end
        if (ctl.st_re)
        begin
            st_q_reg <= st_mem[st_addr];
        end
    end

    // Free-list memory, registered read.
    always_ff @(posedge clk)
    begin
        if (ctl.fl_we)
        begin
            fl_mem[fl_waddr] <= fl_wdata;
        end
        if (ctl.fl_re)
        begin
            fl_q_reg  <= fl_mem[fl_raddr];
            fl_ra_reg <= fl_raddr;
        end
    end

    // Key memory, registered read; never cleared.
    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[key_addr] <= key_wdata;
        end
        if (ctl.key_re)
        begin
            key_q_reg <= key_mem[key_addr];
        end
    end

    // Per-entry valid bits; a pool reinit drops them all at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= '0;
            fl_vld_reg <= '0;
            st_vq_reg  <= 1'b0;
            fl_vq_reg  <= 1'b0;
        end
        else if (ctl.clear)
        begin
            st_vld_reg <= '0;
            fl_vld_reg <= '0;
        end
        else
        begin
            if (ctl.st_re)
            begin
                st_vq_reg <= st_vld_reg[st_addr];
            end
            if (ctl.fl_re)
            begin
                fl_vq_reg <= fl_vld_reg[fl_raddr];
            end
            if (ctl.st_we)
            begin
                st_vld_reg[st_addr] <= 1'b1;
            end
            if (ctl.fl_we)
            begin
                fl_vld_reg[fl_waddr] <= 1'b1;
            end
        end
    end

    // An unwritten status entry reads as unused; an unwritten free-list slot holds its own index.
    assign st_rdata  = st_vq_reg ? st_q_reg : pla_pkg::ST_UNUSED;
    assign fl_rdata  = fl_vq_reg ? fl_q_reg : fl_ra_reg;
    assign key_rdata = key_q_reg;

endmodule
